[sv/imuafd_pkg.sv]
// ----------------------------------------------------------------------------
// IMU angle frame decoder package
// Shared constants and the frame record that passes between the frame
// assembler and the angle scaling stage.
// ----------------------------------------------------------------------------
package imuafd_pkg;

	// Frame layout.
	localparam logic [7:0] FRAME_HEADER = 8'h55;
	localparam logic [7:0] ANGLE_TYPE   = 8'h53;
	localparam int unsigned POS_W       = 4;
	localparam logic [3:0] LAST_POS     = 4'd10;
	localparam int unsigned NUM_STORED  = 9;

	// Field widths.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned DEG_W  = 9;
	localparam logic [8:0]  MAX_DEG = 9'd360;

	// Division by 182: the word is halved, then divided by 91 through a
	// multiplication by ceil(2^21 / 91). The error term stays below one for
	// every 15-bit operand, so the quotient is exact without correction.
	localparam int unsigned HALF_W      = 15;
	localparam int unsigned PROD_W      = 30;
	localparam int unsigned RECIP_SHIFT = 21;
	localparam logic [14:0] RECIP_MULT  = 15'd23046;

	// One completed frame, ready for scaling.
	typedef struct packed {
		logic [15:0] roll_word;
		logic [15:0] pitch_word;
		logic        accept;
	} frame_t;

endpackage

[sv/imu_angle_frame_decoder_top.sv]
// ----------------------------------------------------------------------------
// IMU angle frame decoder
// Assembles 11-byte inertial sensor frames from received serial bytes and
// reports the held roll and pitch angles in whole degrees per frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] = rx_byte
//  m_axis    out        tdata[8:0] = roll_deg, tdata[17:9] = pitch_deg,
//                       tuser[0] = updated
//
//  One byte is taken per cycle unless the stages ahead are stalled. A completed
//  frame, once its last byte is accepted into the input register, passes the
//  frame register, the reciprocal product register and the result register in turn.
//  Reset clears the frame position, header and held angles to zero.
//  Each stage holds while the one after it is full and stalled, so bytes keep flowing
//  in while a result waits as long as an earlier stage has room.
// ----------------------------------------------------------------------------
module imu_angle_frame_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [8:0] roll_deg, [17:9] pitch_deg, [23:18] zero
	output logic [0:0]  m_axis_tuser    // [0] updated
);

	logic                                byte_valid_s1;
	logic [imuafd_pkg::BYTE_W-1:0]       byte_s1;
	logic                                asm_ready;
	logic                                frame_valid_s2;
	imuafd_pkg::frame_t                  frame_s2;
	logic                                frame_ready;
	logic [imuafd_pkg::DEG_W-1:0]        roll_q;
	logic [imuafd_pkg::DEG_W-1:0]        pitch_q;
	logic                                updated_q;

	// Input register.
	assign s_axis_tready = !byte_valid_s1 || asm_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			byte_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Frame assembly.
	imuafd_assembler u_assembler (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (byte_valid_s1),
		.in_byte        (byte_s1),
		.in_ready       (asm_ready),
		.frame_valid_s2 (frame_valid_s2),
		.frame_s2       (frame_s2),
		.frame_ready    (frame_ready)
	);

	// Angle scaling and result register.
	imuafd_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid_s2),
		.frame       (frame_s2),
		.frame_ready (frame_ready),
		.res_valid_q (m_axis_tvalid),
		.roll_q      (roll_q),
		.pitch_q     (pitch_q),
		.updated_q   (updated_q),
		.res_ready   (m_axis_tready)
	);

	// Output packing.
	assign m_axis_tdata = {6'b0, pitch_q, roll_q};
	assign m_axis_tuser = updated_q;

	// A stalled frame record keeps its contents until the scaler takes it.
	a_frame_hold : assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid_s2 && !frame_ready |=> frame_valid_s2 && $stable(frame_s2))
		else $error("frame record changed while stalled");

	// Scaled angles never exceed the full turn.
	a_deg_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (roll_q <= imuafd_pkg::MAX_DEG) && (pitch_q <= imuafd_pkg::MAX_DEG))
		else $error("angle out of range");

	// An empty input register always takes the next item.
	a_in_free : assert property (@(posedge clk) disable iff (!arst_n)
		!byte_valid_s1 |-> s_axis_tready)
		else $error("input refused while input register empty");

endmodule

[sv/imuafd_assembler.sv]
// ----------------------------------------------------------------------------
// IMU angle frame assembler
// Tracks the byte position within an 11-byte frame, stores the header and
// payload bytes, and on completion registers the raw angle words together
// with the type and zero checks.
// ----------------------------------------------------------------------------
module imuafd_assembler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	output logic                 in_ready,
	output logic                 frame_valid_s2,
	output imuafd_pkg::frame_t   frame_s2,
	input  logic                 frame_ready
);

	logic [imuafd_pkg::POS_W-1:0]  pos_q;
	logic [imuafd_pkg::BYTE_W-1:0] header_q;
	logic [imuafd_pkg::BYTE_W-1:0] bytes_q [imuafd_pkg::NUM_STORED];
	logic                          take;
	logic                          complete;
	logic [imuafd_pkg::POS_W-1:0]  wr_idx;
	imuafd_pkg::frame_t            frame_next;

	// An item is taken whenever the frame register is free or draining.
	assign in_ready = !frame_valid_s2 || frame_ready;
	assign take     = in_valid && in_ready;
	assign wr_idx   = pos_q - 4'd1;

	// The final byte completes a frame with a good header.
	always_comb begin
		complete = take && (pos_q != '0) && (header_q == imuafd_pkg::FRAME_HEADER) &&
			(pos_q >= imuafd_pkg::LAST_POS);
		frame_next.roll_word  = {bytes_q[2], bytes_q[1]};
		frame_next.pitch_word = {bytes_q[4], bytes_q[3]};
		frame_next.accept     = (bytes_q[0] == imuafd_pkg::ANGLE_TYPE) &&
			(bytes_q[5] == '0) && (bytes_q[6] == '0) &&
			(bytes_q[7] == '0) && (bytes_q[8] == '0);
	end

	// Position and header tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			header_q <= '0;
		end else if (take) begin
			if (pos_q == '0) begin
				header_q <= in_byte;
				pos_q    <= 4'd1;
			end else if (header_q != imuafd_pkg::FRAME_HEADER) begin
				pos_q <= '0;
			end else if (pos_q < imuafd_pkg::LAST_POS) begin
				pos_q <= pos_q + 4'd1;
			end else begin
				pos_q <= '0;
			end
		end
	end

	// Payload bytes at positions one to nine; the checksum is not kept.
	always_ff @(posedge clk) begin
		if (take && (pos_q != '0) && (header_q == imuafd_pkg::FRAME_HEADER) &&
				(pos_q < imuafd_pkg::LAST_POS)) begin
			bytes_q[wr_idx] <= in_byte;
		end
	end

	// Frame register towards the scaling stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s2 <= 1'b0;
		end else if (in_ready) begin
			frame_valid_s2 <= complete;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			frame_s2 <= frame_next;
		end
	end

endmodule

[sv/imuafd_scale.sv]
// ----------------------------------------------------------------------------
// IMU angle scaling stage
// Divides the raw angle words by 182 with a reciprocal multiplication,
// keeps the held angles and presents the result register.
// ----------------------------------------------------------------------------
module imuafd_scale (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            frame_valid,
	input  imuafd_pkg::frame_t              frame,
	output logic                            frame_ready,
	output logic                            res_valid_q,
	output logic [imuafd_pkg::DEG_W-1:0]    roll_q,
	output logic [imuafd_pkg::DEG_W-1:0]    pitch_q,
	output logic                            updated_q,
	input  logic                            res_ready
);

	logic                              prod_valid_s3;
	logic [imuafd_pkg::PROD_W-1:0]     roll_prod_s3;
	logic [imuafd_pkg::PROD_W-1:0]     pitch_prod_s3;
	logic                              accept_s3;
	logic                              out_ready;
	logic                              s3_ready;
	logic [imuafd_pkg::HALF_W-1:0]     roll_half;
	logic [imuafd_pkg::HALF_W-1:0]     pitch_half;
	logic [imuafd_pkg::DEG_W-1:0]      roll_div;
	logic [imuafd_pkg::DEG_W-1:0]      pitch_div;

	// Flow control between the product register and the result register.
	assign out_ready   = !res_valid_q || res_ready;
	assign s3_ready    = !prod_valid_s3 || out_ready;
	assign frame_ready = s3_ready;

	assign roll_half  = frame.roll_word[imuafd_pkg::WORD_W-1:1];
	assign pitch_half = frame.pitch_word[imuafd_pkg::WORD_W-1:1];

	// Reciprocal products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s3 <= 1'b0;
		end else if (s3_ready) begin
			prod_valid_s3 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && frame_valid) begin
			roll_prod_s3  <= imuafd_pkg::PROD_W'(roll_half) *
				imuafd_pkg::PROD_W'(imuafd_pkg::RECIP_MULT);
			pitch_prod_s3 <= imuafd_pkg::PROD_W'(pitch_half) *
				imuafd_pkg::PROD_W'(imuafd_pkg::RECIP_MULT);
			accept_s3     <= frame.accept;
		end
	end

	// The quotient is the top of the product.
	assign roll_div  = roll_prod_s3[imuafd_pkg::PROD_W-1:imuafd_pkg::RECIP_SHIFT];
	assign pitch_div = pitch_prod_s3[imuafd_pkg::PROD_W-1:imuafd_pkg::RECIP_SHIFT];

	// Result register; the angle registers double as the held angles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			roll_q      <= '0;
			pitch_q     <= '0;
			updated_q   <= 1'b0;
		end else if (out_ready) begin
			res_valid_q <= prod_valid_s3;
			if (prod_valid_s3) begin
				updated_q <= accept_s3;
				if (accept_s3) begin
					roll_q  <= roll_div;
					pitch_q <= pitch_div;
				end
			end
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU angle frame decoder testbench
// Sends received serial bytes into the decoder, a few hand-built frames and
// then random framed traffic with bad headers mixed in. It predicts each
// completed frame's roll, pitch and update flag and checks every output item
// against that prediction. The sender and the receiver idle at random.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned DEG_DIVISOR = 182;
	localparam int unsigned DRAIN_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 12;
	localparam time         RUN_LIMIT   = 4_000_000;

	// One decoded angle item as it leaves the block.
	typedef struct packed {
		logic [8:0] roll;
		logic [8:0] pitch;
		logic       updated;
	} angle_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;   // [8:0] roll_deg, [17:9] pitch_deg, [23:18] zero
	logic [0:0]  m_axis_tuser;   // [0] updated

	// Decoder state as predicted.
	logic [3:0]  frame_pos;
	logic [7:0]  frame_header;
	logic [7:0]  frame_store [1:10];
	logic [8:0]  roll_held;
	logic [8:0]  pitch_held;

	angle_item_t angle_results_q [$];
	angle_item_t angle_expected;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned fail_count = 0;

	imu_angle_frame_decoder_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	// Scale a little-endian raw word to whole degrees.
	function automatic logic [8:0] word_to_deg(input logic [7:0] lo, input logic [7:0] hi);
		int unsigned word;
		word = 32'({hi, lo});
		return 9'(word / DEG_DIVISOR);
	endfunction

	// Advance the predicted decoder by one accepted byte.
	task automatic decode_rx_byte(input logic [7:0] rx);
		logic accept;
		if (frame_pos == 4'd0) begin
			frame_header = rx;
			frame_pos    = 4'd1;
		end else if (frame_header != imuafd_pkg::FRAME_HEADER) begin
			frame_pos = 4'd0;
		end else if (frame_pos < imuafd_pkg::LAST_POS) begin
			frame_store[frame_pos] = rx;
			frame_pos = frame_pos + 4'd1;
		end else begin
			frame_store[imuafd_pkg::LAST_POS] = rx;
			frame_pos = 4'd0;
			accept = (frame_store[1] == imuafd_pkg::ANGLE_TYPE) &&
				(frame_store[6] == 8'h00) &&
				(frame_store[7] == 8'h00) && (frame_store[8] == 8'h00) &&
				(frame_store[9] == 8'h00);
			if (accept) begin
				roll_held  = word_to_deg(frame_store[2], frame_store[3]);
				pitch_held = word_to_deg(frame_store[4], frame_store[5]);
			end
			angle_results_q.push_back('{roll: roll_held, pitch: pitch_held, updated: accept});
		end
	endtask

	// Offer one byte, idling first at random, and wait for it to be taken.
	task automatic send_rx_byte(input logic [7:0] rx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rx;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		decode_rx_byte(rx);
	endtask

	// Send a whole frame: header, type, roll, pitch, four reserved bytes, checksum.
	task automatic send_frame(input logic [7:0] hdr, input logic [7:0] kind,
			input logic [15:0] roll_word, input logic [15:0] pitch_word,
			input logic [31:0] reserved, input logic [7:0] checksum);
		send_rx_byte(hdr);
		send_rx_byte(kind);
		send_rx_byte(roll_word[7:0]);
		send_rx_byte(roll_word[15:8]);
		send_rx_byte(pitch_word[7:0]);
		send_rx_byte(pitch_word[15:8]);
		for (int k = 0; k < 4; k++)
			send_rx_byte(reserved[8*k +: 8]);
		send_rx_byte(checksum);
	endtask

	// Raw angle words, weighted towards the ends of the range and the divisor steps.
	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0: return 16'hFFFF;
			1: return 16'h0000;
			2: return 16'(DEG_DIVISOR);
			3: return 16'(DEG_DIVISOR - 1);
			4: return 16'(DEG_DIVISOR * $urandom_range(360) + $urandom_range(1));
			default: return 16'($urandom());
		endcase
	endfunction

	// A valid angle frame, a frame that fails the type or reserved check, and a
	// header that is not the frame header followed by the byte that it drops.
	task automatic test_directed_frames();
		send_frame(imuafd_pkg::FRAME_HEADER, imuafd_pkg::ANGLE_TYPE, 16'hFFFF,
			16'(DEG_DIVISOR), 32'h0, 8'h00);
		send_rx_byte(8'hAA);
		send_rx_byte(imuafd_pkg::FRAME_HEADER);
		send_frame(imuafd_pkg::FRAME_HEADER, imuafd_pkg::ANGLE_TYPE, 16'(DEG_DIVISOR - 1),
			16'h0000, 32'hFF00_0000, 8'hFF);
	endtask

	// Random traffic under one idling setting, mostly well-formed frames.
	task automatic test_random_frames(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned num_bytes);
		int unsigned sent;
		logic [7:0]  kind;
		logic [31:0] reserved;
		int unsigned slot;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < num_bytes) begin
			if ($urandom_range(99) < 15) begin
				send_rx_byte(8'($urandom_range(255)) ^ ($urandom_range(1) ? 8'h00 : 8'h00));
				if (frame_header == imuafd_pkg::FRAME_HEADER) begin
					// A random header hit the frame header: finish it as a random frame.
					for (int k = 0; k < 10; k++)
						send_rx_byte(8'($urandom()));
					sent += 11;
				end else begin
					send_rx_byte(8'($urandom()));
					sent += 2;
				end
			end else begin
				kind = ($urandom_range(99) < 75) ? imuafd_pkg::ANGLE_TYPE : 8'($urandom());
				reserved = 32'h0;
				if ($urandom_range(99) < 30) begin
					slot = $urandom_range(3);
					reserved = 32'($urandom());
					reserved[8*slot +: 8] = 8'($urandom_range(255, 1));
				end
				send_frame(imuafd_pkg::FRAME_HEADER, kind, pick_word(), pick_word(), reserved,
					8'($urandom()));
				sent += 11;
			end
		end
	endtask

	// Receiver stalls at random.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each output item with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (angle_results_q.size() == 0) begin
				$error("unexpected output item: roll_deg %0d pitch_deg %0d updated %0d",
					m_axis_tdata[8:0], m_axis_tdata[17:9], m_axis_tuser[0]);
				fail_count++;
			end else begin
				angle_expected = angle_results_q.pop_front();
				if (m_axis_tdata[8:0] !== angle_expected.roll) begin
					$error("roll_deg: expected %0d, actual %0d",
						angle_expected.roll, m_axis_tdata[8:0]);
					fail_count++;
				end
				if (m_axis_tdata[17:9] !== angle_expected.pitch) begin
					$error("pitch_deg: expected %0d, actual %0d",
						angle_expected.pitch, m_axis_tdata[17:9]);
					fail_count++;
				end
				if (m_axis_tuser[0] !== angle_expected.updated) begin
					$error("updated: expected %0d, actual %0d",
						angle_expected.updated, m_axis_tuser[0]);
					fail_count++;
				end
			end
		end
	end

	// Overall run limit.
	initial begin
		#(RUN_LIMIT);
		$display("FAIL imu_angle_frame_decoder_top");
		$finish;
	end

	// Reset, the tests in turn, then drain the remaining results.
	initial begin
		int unsigned waited;
		frame_pos    = 4'd0;
		frame_header = 8'h00;
		roll_held    = 9'd0;
		pitch_held   = 9'd0;
		for (int k = 1; k <= 10; k++)
			frame_store[k] = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_random_frames(0, 0, 170);
		test_random_frames(49, 0, 170);
		test_random_frames(0, 49, 170);
		test_random_frames(27, 27, 170);

		s_axis_tvalid <= 1'b0;
		recv_stall_pct = 0;
		waited = 0;
		while (angle_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (angle_results_q.size() != 0) begin
			$error("%0d expected output items never arrived", angle_results_q.size());
			fail_count++;
		end

		if (fail_count == 0)
			$display("PASS imu_angle_frame_decoder_top");
		else
			$display("FAIL imu_angle_frame_decoder_top");
		$finish;
	end

endmodule

[filelist.f]
sv/imuafd_pkg.sv
sv/imuafd_assembler.sv
sv/imuafd_scale.sv
sv/imu_angle_frame_decoder_top.sv
tb/tb.sv
